/* rtl/lmsd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmsd_pkg: shared types and constants of the led matrix scan driver
// Holds the beat structs, frame buffer geometry and controller commands.
// ----------------------------------------------------------------------------
package lmsd_pkg;

    // frame buffer geometry: two halves of 16 rows, 16 columns per word
    localparam int WORD_W    = 16;
    localparam int NUM_ROWS  = 16;
    localparam int ROW_W     = 4;
    localparam int FB_DEPTH  = 32;
    localparam int FB_ADDR_W = 5;

    // number of shift beats per row scan, at most 16 (4-bit beat counter)
    localparam int SHIFT_LEN = 16;
    localparam logic [3:0] LAST_BEAT = 4'(SHIFT_LEN - 1);

    // divider and register defaults
    localparam logic [15:0] INTERVAL_RESET = 16'd1;
    localparam logic [15:0] TICK_RESET     = 16'd1;

    // configuration register index, taken from the word address
    localparam logic REG_SCAN_INTERVAL = 1'b0;

    // input item function codes
    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    // column 0 of a half sits at the most significant bit
    localparam logic [WORD_W-1:0] COL0_MASK = 16'h8000;

    typedef struct packed {
        logic       func;
        logic [5:0] pos_x;
        logic [4:0] pos_y;
        logic [7:0] pixel_level;
    } t_item;

    typedef struct packed {
        logic       row_select_bit;
        logic       left_half_bit;
        logic       right_half_bit;
        logic [3:0] beat_index;
        logic [3:0] scan_row;
        logic       latch_after;
    } t_result;

    // frame buffer read address source
    typedef enum logic [1:0] {
        RD_PIX,
        RD_LEFT,
        RD_RIGHT
    } t_rd_sel;

    // commands from controller to datapath
    typedef struct packed {
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    cap_pix;
        logic    wr_en;
        logic    tick_dec;
        logic    tick_reload;
        logic    load_left;
        logic    load_right;
        logic    emit;
        logic    row_adv;
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic tick_zero;
        logic pix_ok;
        logic last_beat;
    } t_dp_status;

endpackage

/* rtl/lmsd_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmsd_ram: generic single write, single read ram
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lmsd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/lmsd_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmsd_ctrl: controller of the led matrix scan driver
// Sequences pixel read-modify-write, divider ticks and row scan beats.
// ----------------------------------------------------------------------------
module lmsd_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_func,
    input  lmsd_pkg::t_dp_status i_status,
    output lmsd_pkg::t_dp_cmd   o_cmd,
    output logic                o_busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PIX_WR,
        S_SCAN_L,
        S_SCAN_R,
        S_SHIFT
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, n_busy;
    logic   w_accept;

    assign w_accept = i_start && !r_busy;

    // next state and command decode
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.rd_sel = lmsd_pkg::RD_PIX;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_func == lmsd_pkg::FUNC_PIXEL) begin
                        if (i_status.pix_ok) begin
                            o_cmd.rd_en   = 1'b1;
                            o_cmd.rd_sel  = lmsd_pkg::RD_PIX;
                            o_cmd.cap_pix = 1'b1;
                            n_state       = S_PIX_WR;
                        end
                    end else if (i_status.tick_zero) begin
                        o_cmd.tick_reload = 1'b1;
                        o_cmd.rd_en       = 1'b1;
                        o_cmd.rd_sel      = lmsd_pkg::RD_LEFT;
                        n_state           = S_SCAN_L;
                    end else begin
                        o_cmd.tick_dec = 1'b1;
                    end
                end
            end
            S_PIX_WR: begin
                o_cmd.wr_en = 1'b1;
                n_state     = S_IDLE;
            end
            S_SCAN_L: begin
                o_cmd.load_left = 1'b1;
                o_cmd.rd_en     = 1'b1;
                o_cmd.rd_sel    = lmsd_pkg::RD_RIGHT;
                n_state         = S_SCAN_R;
            end
            S_SCAN_R: begin
                o_cmd.load_right = 1'b1;
                n_state          = S_SHIFT;
            end
            S_SHIFT: begin
                o_cmd.emit = 1'b1;
                if (i_status.last_beat) begin
                    o_cmd.row_adv = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_busy = (n_state != S_IDLE);
    end

    // state and busy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
        end
    end

    assign o_busy = r_busy;

endmodule

/* rtl/lmsd_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmsd_datapath: frame buffer, divider, row counter and beat output
// Executes controller commands and drives the registered result beats.
// ----------------------------------------------------------------------------
module lmsd_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lmsd_pkg::t_item      i_item,
    input  logic [15:0]          i_scan_interval,
    input  lmsd_pkg::t_dp_cmd    i_cmd,
    output lmsd_pkg::t_dp_status o_status,
    output logic                 o_res_valid,
    output lmsd_pkg::t_result    o_result
);

    logic [lmsd_pkg::FB_DEPTH-1:0]  r_valid;
    logic                           r_rd_vld;
    logic [15:0]                    r_tick_cnt;
    logic [lmsd_pkg::ROW_W-1:0]     r_row;
    logic [3:0]                     r_beat;
    logic [lmsd_pkg::WORD_W-1:0]    r_left;
    logic [lmsd_pkg::WORD_W-1:0]    r_right;
    logic [lmsd_pkg::FB_ADDR_W-1:0] r_pix_addr;
    logic [lmsd_pkg::WORD_W-1:0]    r_pix_mask;
    logic                           r_pix_on;
    logic                           r_out_valid;
    lmsd_pkg::t_result              r_out;

    logic [lmsd_pkg::FB_ADDR_W-1:0] w_rd_addr;
    logic [lmsd_pkg::FB_ADDR_W-1:0] w_pix_addr;
    logic [lmsd_pkg::WORD_W-1:0]    w_rd_data;
    logic [lmsd_pkg::WORD_W-1:0]    w_rd_word;
    logic [lmsd_pkg::WORD_W-1:0]    w_wr_word;

    // pixel address: half from column bit 4, row in low bits
    assign w_pix_addr = {i_item.pos_x[4], i_item.pos_y[3:0]};

    // read address select
    always_comb begin
        unique case (i_cmd.rd_sel)
            lmsd_pkg::RD_PIX:   w_rd_addr = w_pix_addr;
            lmsd_pkg::RD_LEFT:  w_rd_addr = {1'b0, r_row};
            lmsd_pkg::RD_RIGHT: w_rd_addr = {1'b1, r_row};
            default:            w_rd_addr = w_pix_addr;
        endcase
    end

    lmsd_ram #(
        .WIDTH(lmsd_pkg::WORD_W),
        .DEPTH(lmsd_pkg::FB_DEPTH)
    ) u_fb_ram (
        .i_clk    (i_clk),
        .i_wr_en  (i_cmd.wr_en),
        .i_wr_addr(r_pix_addr),
        .i_wr_data(w_wr_word),
        .i_rd_en  (i_cmd.rd_en),
        .i_rd_addr(w_rd_addr),
        .o_rd_data(w_rd_data)
    );

    // never written rows read as dark
    assign w_rd_word = r_rd_vld ? w_rd_data : '0;

    // pixel merge into the row word
    assign w_wr_word = r_pix_on ? (w_rd_word | r_pix_mask) : (w_rd_word & ~r_pix_mask);

    // status to controller
    assign o_status.tick_zero = (r_tick_cnt == '0);
    assign o_status.pix_ok    = !i_item.pos_x[5] && !i_item.pos_y[4];
    assign o_status.last_beat = (r_beat == lmsd_pkg::LAST_BEAT);

    // control state: valid bits, divider, row and beat counters, strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_tick_cnt  <= lmsd_pkg::TICK_RESET;
            r_row       <= '0;
            r_beat      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.wr_en) begin
                r_valid[r_pix_addr] <= 1'b1;
            end
            if (i_cmd.tick_reload) begin
                r_tick_cnt <= i_scan_interval;
            end else if (i_cmd.tick_dec) begin
                r_tick_cnt <= r_tick_cnt - 16'd1;
            end
            if (i_cmd.row_adv) begin
                r_row <= r_row + 4'd1;
            end
            if (i_cmd.load_right) begin
                r_beat <= '0;
            end else if (i_cmd.emit) begin
                r_beat <= r_beat + 4'd1;
            end
            r_out_valid <= i_cmd.emit;
        end
    end

    // payload: read valid, captured pixel, row words, beat fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_vld <= r_valid[w_rd_addr];
        end
        if (i_cmd.cap_pix) begin
            r_pix_addr <= w_pix_addr;
            r_pix_mask <= lmsd_pkg::COL0_MASK >> i_item.pos_x[3:0];
            r_pix_on   <= (i_item.pixel_level != 8'd0);
        end
        if (i_cmd.load_left) begin
            r_left <= w_rd_word;
        end
        if (i_cmd.load_right) begin
            r_right <= w_rd_word;
        end
        if (i_cmd.emit) begin
            r_out.row_select_bit <= (r_beat == r_row);
            r_out.left_half_bit  <= r_left[r_beat];
            r_out.right_half_bit <= r_right[r_beat];
            r_out.beat_index     <= r_beat;
            r_out.scan_row       <= r_row;
            r_out.latch_after    <= (r_beat == lmsd_pkg::LAST_BEAT);
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_result    = r_out;

endmodule

/* rtl/led_matrix_scan_driver.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_matrix_scan_driver: row scan driver for a 32x16 one colour led matrix
// Frame buffer of pixel bits, tick divider and serial shift beat generator.
// ----------------------------------------------------------------------------
// pixel write: busy for 1 cycle after accept (ram read, then write back)
// tick without scan: divider counts down, busy stays low
// scanning tick: left then right row word read from ram (SCAN_L, SCAN_R),
//   then SHIFT_LEN beats on consecutive cycles, busy through the scan
// results cannot be stalled; one beat per cycle, indexed by the beat counter
// sync reset: row 0, divider 1, interval 1, buffer dark via per-row valid bits
module led_matrix_scan_driver (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  lmsd_pkg::t_item   i_item,
    output logic              o_res_valid,
    output lmsd_pkg::t_result o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic                 w_sel_interval;
    logic [15:0]          r_interval;
    lmsd_pkg::t_dp_cmd    w_cmd;
    lmsd_pkg::t_dp_status w_status;
    logic                 w_cfg_wr;

    // apb register write
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign w_sel_interval = (paddr[2] == lmsd_pkg::REG_SCAN_INTERVAL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= lmsd_pkg::INTERVAL_RESET;
        end else if (w_cfg_wr && w_sel_interval) begin
            r_interval <= pwdata[15:0];
        end
    end

    // apb register read
    assign prdata = w_sel_interval ? {16'd0, r_interval} : 32'd0;

    lmsd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_func  (i_item.func),
        .i_status(w_status),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    lmsd_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (i_item),
        .i_scan_interval(r_interval),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .o_res_valid    (o_res_valid),
        .o_result       (o_result)
    );

`ifndef SYNTHESIS
    // beats only come out of a scan that holds the block busy
    a_beat_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> $past(busy))
        else $error("result beat without a scan in progress");

    // latch request only on the last beat
    a_latch_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_result.latch_after) |->
            (o_result.beat_index == lmsd_pkg::LAST_BEAT))
        else $error("latch request on a beat other than the last");

    // row select is one-hot on the scanned row
    a_row_sel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |->
            (o_result.row_select_bit == (o_result.beat_index == o_result.scan_row)))
        else $error("row select bit does not match scan row");

    // a scan ends with a gap in the beat stream
    a_scan_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_result.latch_after) |=> !o_res_valid)
        else $error("beat directly after latch request");
`endif

endmodule
